// File: hw/rtl/fbal_pkg.sv
// Shared constants for the framed byte link: opcodes, register indexes and
// stream field widths. No dependencies.
`default_nettype none

package fbal_pkg;

    // input opcodes (s_tuser)
    localparam logic [1:0] OP_LINE  = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    // configuration register indexes
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_SYNC     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ADDR     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACK      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_END      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PREAMBLE = 3'd4;

    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 32;

endpackage

`default_nettype wire

// File: hw/rtl/framed_byte_ack_link.sv
// Framed byte link: receive/transmit sequencers, config registers, result register.
// Depends on fbal_pkg and fbal_txstore.
//
// Usage: each input transaction (s_*) is one event. s_tuser holds the opcode:
// line event, load of a transmit store byte, or start of transmission with a
// length. Every input transaction yields exactly one result transaction on
// m_*, carrying send/stored/frame-done flags and the mode after the event.
// The result is registered at the accepting edge, together with the transmit
// store read data (the store is a synchronous RAM read at the accepting edge).
// Throughput is one event per cycle; s_tready drops only while a finished
// result is held and m_tready is low. A load is visible to a read issued in
// the next accepted transaction, so loads and transmits may be mixed freely.
// Configuration writes (cfg_*) are always ready and take effect at once;
// write them only while no result is outstanding.
// Reset (aresetn low, synchronous) puts both sequencers at their start, the
// block in receive mode with the receiver on, the byte count and length at
// zero, and registers at their defaults (preamble count 1). The transmit
// store has no reset; entries must be loaded before they are sent.
`default_nettype none

module framed_byte_ack_link #(
    parameter int unsigned FRAME_CAPACITY = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // {frame_length[32:24], load_byte[23:16], load_index[15:8], line_byte[7:0]}
    input  wire logic [fbal_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]                          s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // {transmit_mode[29], receiver_on[28], tx_frame_done[27], rx_frame_done[26],
    //  stored_byte[25:18], stored_index[17:10], stored_valid[9], send_byte[8:1],
    //  send_valid[0]}
    output logic [fbal_pkg::M_TDATA_W-1:0]           m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [fbal_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire logic [fbal_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned AW = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
    localparam int unsigned CW = $clog2(FRAME_CAPACITY + 65);
    localparam int unsigned LW = (CW > 8) ? CW : 8;
    localparam int unsigned TW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] CNT_MAX = CW'(FRAME_CAPACITY + 64);
    localparam logic [CW-1:0] CAP_C   = CW'(FRAME_CAPACITY);

    typedef enum logic [2:0] {
        RX_INIT    = 3'd0,
        RX_SYNC    = 3'd1,
        RX_ADDR    = 3'd2,
        RX_ACKWAIT = 3'd3,
        RX_DATA    = 3'd4,
        RX_DONE    = 3'd5
    } rx_phase_t;

    typedef enum logic [2:0] {
        TX_INIT    = 3'd0,
        TX_PRE     = 3'd1,
        TX_ACKWAIT = 3'd2,
        TX_DATA    = 3'd3,
        TX_DONE    = 3'd5
    } tx_phase_t;

    typedef struct packed {
        logic       send_valid;
        logic       stored_valid;
        logic [7:0] stored_index;
        logic [7:0] stored_byte;
        logic       rx_done;
        logic       tx_done;
        logic       receiver_on;
        logic       transmit_mode;
    } res_t;

    // input fields
    logic [1:0] opcode;
    logic [7:0] line_byte;
    logic [7:0] load_index;
    logic [7:0] load_byte;
    logic [8:0] frame_length;

    assign opcode       = s_tuser;
    assign line_byte    = s_tdata[7:0];
    assign load_index   = s_tdata[15:8];
    assign load_byte    = s_tdata[23:16];
    assign frame_length = s_tdata[32:24];

    // configuration
    logic [7:0] sync_reg, addr_reg, ack_reg, end_reg;
    logic [4:0] preamble_reg;

    // sequencer state
    rx_phase_t     rx_phase_reg, rx_phase_next;
    tx_phase_t     tx_phase_reg, tx_phase_next;
    logic          mode_reg, mode_next;
    logic          rcv_on_reg, rcv_on_next;
    logic [CW-1:0] count_reg, count_next;
    logic [8:0]    tx_len_reg, tx_len_next;

    // result stage
    logic       out_vld_reg;
    res_t       res_reg, res_next;
    logic       send_sel_reg, send_sel_next;  // send byte comes from store
    logic [7:0] send_byte_reg, send_byte_next;

    // store access
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    logic s_fire;

    assign s_tready  = !out_vld_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign wr_en = s_fire && (opcode == fbal_pkg::OP_LOAD)
                   && (LW'(load_index) < LW'(FRAME_CAPACITY));

    always_comb begin
        logic [CW-1:0] cnt;
        logic [CW-1:0] cnt_inc;
        tx_phase_t     tph;
        logic          in_range;

        rx_phase_next  = rx_phase_reg;
        tx_phase_next  = tx_phase_reg;
        mode_next      = mode_reg;
        rcv_on_next    = rcv_on_reg;
        count_next     = count_reg;
        tx_len_next    = tx_len_reg;
        res_next       = '0;
        send_sel_next  = 1'b0;
        send_byte_next = 8'd0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        cnt            = count_reg;
        cnt_inc        = count_reg;
        tph            = tx_phase_reg;
        in_range       = 1'b0;

        if (opcode == fbal_pkg::OP_START) begin
            tx_len_next = frame_length;
            mode_next   = 1'b1;
            tph         = TX_INIT;
        end

        if ((opcode == fbal_pkg::OP_START) ||
            ((opcode == fbal_pkg::OP_LINE) && mode_reg)) begin
            // transmit sequencer
            case (tph)
                TX_INIT, TX_PRE, TX_DATA: begin
                    if (tph == TX_INIT) begin
                        cnt = '0;
                        tx_phase_next = TX_PRE;
                    end else begin
                        tx_phase_next = tph;
                    end
                    rcv_on_next = 1'b0;
                    if (tph == TX_PRE) begin
                        rcv_on_next = rcv_on_reg;
                    end
                    cnt_inc  = (cnt < CNT_MAX) ? cnt + 1'b1 : cnt;
                    in_range = cnt < CAP_C;
                    rd_en    = in_range;
                    rd_addr  = AW'(cnt);
                    res_next.send_valid = 1'b1;
                    send_sel_next = in_range;
                    count_next = cnt_inc;
                    if (tph == TX_DATA) begin
                        tx_phase_next = TX_ACKWAIT;
                    end else if (cnt_inc >= CW'(preamble_reg)) begin
                        tx_phase_next = TX_ACKWAIT;
                    end
                end
                TX_ACKWAIT: begin
                    rcv_on_next   = 1'b1;
                    tx_phase_next = (TW'(count_reg) >= TW'(tx_len_reg)) ? TX_DONE : TX_DATA;
                end
                TX_DONE: begin
                    mode_next        = 1'b0;
                    rcv_on_next      = 1'b1;
                    res_next.tx_done = 1'b1;
                    tx_phase_next    = TX_INIT;
                end
                default: begin
                    tx_phase_next = TX_INIT;
                end
            endcase
        end else if (opcode == fbal_pkg::OP_LINE) begin
            // receive sequencer
            case (rx_phase_reg)
                RX_INIT, RX_SYNC, RX_ADDR, RX_DATA: begin
                    if (rx_phase_reg == RX_INIT) begin
                        rcv_on_next   = 1'b1;
                        cnt           = '0;
                        count_next    = '0;
                        rx_phase_next = RX_SYNC;
                    end
                    cnt_inc = (cnt < CNT_MAX) ? cnt + 1'b1 : cnt;
                    if ((rx_phase_reg == RX_INIT) || (rx_phase_reg == RX_SYNC)) begin
                        if (line_byte == sync_reg) begin
                            res_next.stored_valid = cnt < CAP_C;
                            count_next    = cnt_inc;
                            rx_phase_next = RX_ADDR;
                        end
                    end else if ((rx_phase_reg == RX_DATA) || (line_byte == addr_reg)) begin
                        res_next.stored_valid = cnt < CAP_C;
                        count_next     = cnt_inc;
                        rcv_on_next    = 1'b0;
                        res_next.send_valid = 1'b1;
                        send_byte_next = ack_reg;
                        if ((rx_phase_reg == RX_DATA) && (line_byte == end_reg)) begin
                            rx_phase_next = RX_DONE;
                        end else begin
                            rx_phase_next = RX_ACKWAIT;
                        end
                    end else begin
                        // address mismatch: restart the sync search
                        rx_phase_next = RX_INIT;
                    end
                    if (res_next.stored_valid) begin
                        res_next.stored_index = 8'(cnt);
                        res_next.stored_byte  = line_byte;
                    end
                end
                RX_ACKWAIT: begin
                    rcv_on_next   = 1'b1;
                    rx_phase_next = RX_DATA;
                end
                RX_DONE: begin
                    res_next.send_valid = 1'b1;
                    send_byte_next      = ack_reg;
                    res_next.rx_done    = 1'b1;
                    rx_phase_next       = RX_INIT;
                end
                default: begin
                    rx_phase_next = RX_INIT;
                end
            endcase
        end

        res_next.receiver_on   = rcv_on_next;
        res_next.transmit_mode = mode_next;
    end

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg     <= 8'd0;
            addr_reg     <= 8'd0;
            ack_reg      <= 8'd0;
            end_reg      <= 8'd0;
            preamble_reg <= 5'd1;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fbal_pkg::REG_SYNC:     sync_reg     <= cfg_data[7:0];
                fbal_pkg::REG_ADDR:     addr_reg     <= cfg_data[7:0];
                fbal_pkg::REG_ACK:      ack_reg      <= cfg_data[7:0];
                fbal_pkg::REG_END:      end_reg      <= cfg_data[7:0];
                fbal_pkg::REG_PREAMBLE: preamble_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase_reg  <= RX_INIT;
            tx_phase_reg  <= TX_INIT;
            mode_reg      <= 1'b0;
            rcv_on_reg    <= 1'b1;
            count_reg     <= '0;
            tx_len_reg    <= 9'd0;
            out_vld_reg   <= 1'b0;
            res_reg       <= '0;
            send_sel_reg  <= 1'b0;
            send_byte_reg <= 8'd0;
        end else begin
            if (s_fire) begin
                rx_phase_reg  <= rx_phase_next;
                tx_phase_reg  <= tx_phase_next;
                mode_reg      <= mode_next;
                rcv_on_reg    <= rcv_on_next;
                count_reg     <= count_next;
                tx_len_reg    <= tx_len_next;
                out_vld_reg   <= 1'b1;
                res_reg       <= res_next;
                send_sel_reg  <= send_sel_next;
                send_byte_reg <= send_byte_next;
            end else if (m_tready) begin
                out_vld_reg  <= 1'b0;
            end
        end
    end

    fbal_txstore #(
        .DEPTH (FRAME_CAPACITY),
        .AW    (AW)
    ) u_txstore (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(load_index)),
        .wr_data (load_byte),
        .rd_en   (s_fire && rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [7:0] send_byte_out;
    assign send_byte_out = send_sel_reg ? rd_data : send_byte_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00,
                       res_reg.transmit_mode,
                       res_reg.receiver_on,
                       res_reg.tx_done,
                       res_reg.rx_done,
                       res_reg.stored_byte,
                       res_reg.stored_index,
                       res_reg.stored_valid,
                       send_byte_out,
                       res_reg.send_valid};

`ifndef SYNTHESIS
    // receive mode always leaves the transmit sequencer at its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        !mode_reg |-> (tx_phase_reg == TX_INIT))
        else $error("transmit sequencer active in receive mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("byte count beyond saturation");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && res_reg.stored_valid |-> !send_sel_reg)
        else $error("store read issued on a receive transaction");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && res_reg.tx_done |-> !res_reg.transmit_mode && res_reg.receiver_on)
        else $error("transmit done without returning to receive mode");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && res_reg.rx_done |-> res_reg.send_valid && !send_sel_reg)
        else $error("frame done without acknowledge");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/fbal_txstore.sv
// Transmit frame store: one write port, one read port with registered data.
// Depends on nothing.
`default_nettype none

module fbal_txstore #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: bench/framed_byte_ack_link_tb.sv
// Self-checking bench for framed_byte_ack_link: random stream traffic with a
// scoreboard that predicts each result transaction from its own link model.
// Depends on fbal_pkg and the framed_byte_ack_link RTL.
`default_nettype none

module framed_byte_ack_link_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_CAP      = 256;
    localparam int unsigned WATCHDOG_LIMIT = 200;
    localparam logic [1:0]  OP_UNUSED      = 2'd3;

    typedef enum logic [2:0] {
        RXS_IDLE, RXS_HUNT, RXS_ADDR, RXS_ACK_GAP, RXS_DATA, RXS_CLOSE
    } rx_state_t;

    typedef enum logic [2:0] {
        TXS_IDLE, TXS_PREAMBLE, TXS_ACK_GAP, TXS_DATA, TXS_CLOSE
    } tx_state_t;

    // m_tdata layout, msb first
    typedef struct packed {
        logic [1:0] pad;
        logic       transmit_mode;
        logic       receiver_on;
        logic       tx_frame_done;
        logic       rx_frame_done;
        logic [7:0] stored_byte;
        logic [7:0] stored_index;
        logic       stored_valid;
        logic [7:0] send_byte;
        logic       send_valid;
    } link_result_t;

    class link_scoreboard;
        logic [7:0]   sync_b, addr_b, ack_b, end_b;
        logic [4:0]   preamble_n;
        rx_state_t    rx_state;
        tx_state_t    tx_state;
        bit           tx_mode, rcv_on;
        int unsigned  byte_cnt;
        logic [8:0]   tx_len;
        logic [7:0]   frame_store [FRAME_CAP];
        link_result_t res;
        link_result_t pending [$];
        int           errors, items, frames_rx, frames_tx, dropped_bytes;

        function new();
            sync_b     = 8'h00;
            addr_b     = 8'h00;
            ack_b      = 8'h00;
            end_b      = 8'h00;
            preamble_n = 5'd1;
            rx_state   = RXS_IDLE;
            tx_state   = TXS_IDLE;
            tx_mode    = 1'b0;
            rcv_on     = 1'b1;
            byte_cnt   = 0;
            tx_len     = '0;
        endfunction

        function void write_reg(logic [fbal_pkg::REG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                fbal_pkg::REG_SYNC:     sync_b = val;
                fbal_pkg::REG_ADDR:     addr_b = val;
                fbal_pkg::REG_ACK:      ack_b = val;
                fbal_pkg::REG_END:      end_b = val;
                fbal_pkg::REG_PREAMBLE: preamble_n = val[4:0];
                default: ;
            endcase
        endfunction

        // shared rx/tx byte counter, saturates well past capacity
        function void bump_count();
            if (byte_cnt < FRAME_CAP + 64)
                byte_cnt++;
        endfunction

        function void store_rx(logic [7:0] b);
            if (byte_cnt < FRAME_CAP) begin
                res.stored_valid = 1'b1;
                res.stored_index = byte_cnt[7:0];
                res.stored_byte  = b;
            end else begin
                dropped_bytes++;
            end
            bump_count();
        endfunction

        function void send_ack();
            res.send_valid = 1'b1;
            res.send_byte  = ack_b;
        endfunction

        function void send_store_byte();
            res.send_valid = 1'b1;
            res.send_byte  = (byte_cnt < FRAME_CAP) ? frame_store[byte_cnt] : 8'h00;
            bump_count();
        endfunction

        function void rx_advance(logic [7:0] b);
            case (rx_state)
                RXS_IDLE, RXS_HUNT: begin
                    if (rx_state == RXS_IDLE) begin
                        rcv_on   = 1'b1;
                        byte_cnt = 0;
                        rx_state = RXS_HUNT;
                    end
                    if (b == sync_b) begin
                        store_rx(b);
                        rx_state = RXS_ADDR;
                    end
                end
                RXS_ADDR: begin
                    if (b == addr_b) begin
                        store_rx(b);
                        rcv_on = 1'b0;
                        send_ack();
                        rx_state = RXS_ACK_GAP;
                    end else begin
                        rx_state = RXS_IDLE;
                    end
                end
                RXS_ACK_GAP: begin
                    rcv_on   = 1'b1;
                    rx_state = RXS_DATA;
                end
                RXS_DATA: begin
                    store_rx(b);
                    rcv_on = 1'b0;
                    send_ack();
                    rx_state = (b == end_b) ? RXS_CLOSE : RXS_ACK_GAP;
                end
                RXS_CLOSE: begin
                    send_ack();
                    res.rx_frame_done = 1'b1;
                    frames_rx++;
                    rx_state = RXS_IDLE;
                end
                default: rx_state = RXS_IDLE;
            endcase
        endfunction

        function void tx_advance();
            case (tx_state)
                TXS_IDLE, TXS_PREAMBLE: begin
                    if (tx_state == TXS_IDLE) begin
                        rcv_on   = 1'b0;
                        byte_cnt = 0;
                        tx_state = TXS_PREAMBLE;
                    end
                    send_store_byte();
                    // a preamble count of zero still sends one byte
                    if (byte_cnt >= preamble_n)
                        tx_state = TXS_ACK_GAP;
                end
                TXS_ACK_GAP: begin
                    rcv_on   = 1'b1;
                    tx_state = (byte_cnt >= tx_len) ? TXS_CLOSE : TXS_DATA;
                end
                TXS_DATA: begin
                    rcv_on = 1'b0;
                    send_store_byte();
                    tx_state = TXS_ACK_GAP;
                end
                TXS_CLOSE: begin
                    tx_mode = 1'b0;
                    rcv_on  = 1'b1;
                    res.tx_frame_done = 1'b1;
                    frames_tx++;
                    tx_state = TXS_IDLE;
                end
                default: tx_state = TXS_IDLE;
            endcase
        endfunction

        function void note_item(logic [1:0] op, logic [7:0] line_b, logic [7:0] ld_idx,
                                logic [7:0] ld_b, logic [8:0] len);
            res = '0;
            case (op)
                fbal_pkg::OP_LINE: begin
                    // in transmit mode the line byte is ignored
                    if (tx_mode)
                        tx_advance();
                    else
                        rx_advance(line_b);
                end
                fbal_pkg::OP_LOAD: frame_store[ld_idx] = ld_b;
                fbal_pkg::OP_START: begin
                    tx_len   = len;
                    tx_mode  = 1'b1;
                    tx_state = TXS_IDLE;
                    tx_advance();
                end
                default: ;
            endcase
            res.receiver_on   = rcv_on;
            res.transmit_mode = tx_mode;
            pending.push_back(res);
            items++;
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [fbal_pkg::M_TDATA_W-1:0] raw);
            link_result_t got, want;
            got = raw;
            if (pending.size() == 0) begin
                $error("result transaction 0x%08h with no prediction pending", raw);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("send_valid", want.send_valid, got.send_valid);
            check_field("send_byte", want.send_byte, got.send_byte);
            check_field("stored_valid", want.stored_valid, got.stored_valid);
            check_field("stored_index", want.stored_index, got.stored_index);
            check_field("stored_byte", want.stored_byte, got.stored_byte);
            check_field("rx_frame_done", want.rx_frame_done, got.rx_frame_done);
            check_field("tx_frame_done", want.tx_frame_done, got.tx_frame_done);
            check_field("receiver_on", want.receiver_on, got.receiver_on);
            check_field("transmit_mode", want.transmit_mode, got.transmit_mode);
            check_field("padding", want.pad, got.pad);
        endfunction
    endclass

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic [fbal_pkg::S_TDATA_W-1:0]      s_tdata = '0;
    logic [1:0]                          s_tuser = '0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [fbal_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [fbal_pkg::REG_IDX_W-1:0]      cfg_index = '0;
    logic [fbal_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    bit                     send_idle_on = 1'b1;
    bit                     recv_idle_on = 1'b1;
    int unsigned            quiet_cycles = 0;
    link_scoreboard         sb = new();

    framed_byte_ack_link i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns aclk = ~aclk;

    // no transaction of any kind for too long means the block is stuck
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, check each accepted transaction
    initial begin
        int stall;
        forever begin
            stall = recv_idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            sb.check_result(m_tdata);
        end
    end

    // s_tvalid stays high across back-to-back transactions
    task automatic push_item(logic [1:0] op, logic [7:0] line_b, logic [7:0] ld_idx,
                             logic [7:0] ld_b, logic [8:0] len);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, len, ld_b, ld_idx, line_b};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, line_b, ld_idx, ld_b, len);
    endtask

    task automatic line_event(logic [7:0] b);
        push_item(fbal_pkg::OP_LINE, b, 8'($urandom), 8'($urandom),
                  9'($urandom_range(0, 256)));
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] val);
        push_item(fbal_pkg::OP_LOAD, 8'($urandom), idx, val, 9'($urandom_range(0, 256)));
    endtask

    task automatic start_tx(logic [8:0] len);
        push_item(fbal_pkg::OP_START, 8'($urandom), 8'($urandom), 8'($urandom), len);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [fbal_pkg::REG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(logic [7:0] sync_v, logic [7:0] addr_v, logic [7:0] ack_v,
                             logic [7:0] end_v, logic [4:0] pre_v);
        wait_drained();
        write_reg(fbal_pkg::REG_SYNC, sync_v);
        write_reg(fbal_pkg::REG_ADDR, addr_v);
        write_reg(fbal_pkg::REG_ACK, ack_v);
        write_reg(fbal_pkg::REG_END, end_v);
        write_reg(fbal_pkg::REG_PREAMBLE, {3'd0, pre_v});
        cfg_valid <= 1'b0;
    endtask

    // bring the block back to receive mode, hunting for a sync byte
    task automatic settle_link();
        if (sb.tx_mode)
            start_tx(9'd0);
        while (sb.tx_mode) line_event(8'($urandom));
        while (sb.rx_state != RXS_IDLE && sb.rx_state != RXS_HUNT)
            line_event(sb.end_b);
    endtask

    task automatic rx_frame(int n_data);
        logic [7:0] b;
        settle_link();
        line_event(sb.sync_b);
        if ($urandom_range(0, 5) == 0) begin
            do b = 8'($urandom); while (b == sb.addr_b);
            line_event(b);
            line_event(sb.sync_b);
        end
        line_event(sb.addr_b);
        repeat (n_data) begin
            line_event(8'($urandom));
            do b = 8'($urandom); while (b == sb.end_b);
            line_event(b);
        end
        line_event(8'($urandom));
        line_event(sb.end_b);
        line_event(8'($urandom));
    endtask

    task automatic tx_frame(logic [8:0] len);
        settle_link();
        start_tx(len);
        while (sb.tx_mode) begin
            if ($urandom_range(0, 7) == 0)
                load_entry(8'($urandom), 8'($urandom));
            line_event(8'($urandom));
        end
    endtask

    task automatic run_phase(int budget);
        int stop_at;
        int pick;
        stop_at = sb.items + budget;
        while (sb.items < stop_at) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                rx_frame($urandom_range(0, 8));
            end else if (pick < 75) begin
                tx_frame(9'($urandom_range(0, 24)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) load_entry(8'($urandom), 8'($urandom));
            end else begin
                // noise: any opcode, any field values, frames left half done
                repeat ($urandom_range(1, 6))
                    push_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              9'($urandom_range(0, 256)));
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    task automatic random_config();
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  5'($urandom_range(0, 16)));
    endtask

    initial begin
        int failures;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        configure(8'hA5, 8'h3C, 8'h5A, 8'h7E, 5'd0);
        // every store entry gets written before anything is transmitted
        for (int i = 0; i < FRAME_CAP; i++)
            load_entry(8'(i), 8'($urandom));

        push_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 9'd256);
        line_event(8'h00);
        line_event(8'hA5);
        line_event(8'hFF);      // wrong address
        line_event(8'hA5);
        line_event(8'h3C);
        line_event(8'hFF);
        line_event(8'h00);
        line_event(8'h00);
        line_event(8'hFF);
        line_event(8'h12);
        line_event(8'h7E);
        line_event(8'h00);
        start_tx(9'd2);
        repeat (4) line_event(8'hFF);
        start_tx(9'd256);
        line_event(8'h00);
        line_event(8'h00);
        start_tx(9'd0);         // restart while transmitting
        while (sb.tx_mode) line_event(8'($urandom));

        configure(8'h00, 8'h00, 8'h00, 8'h00, 5'd1);
        run_phase(60);
        configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd16);
        run_phase(60);
        random_config();
        rx_frame(256);          // runs past capacity
        tx_frame(9'd256);
        run_phase(60);
        repeat (2) begin
            random_config();
            run_phase(60);
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        failures = sb.errors + sb.pending.size();
        $display("%0d transactions: %0d frames received, %0d frames sent, %0d bytes past capacity",
                 sb.items, sb.frames_rx, sb.frames_tx, sb.dropped_bytes);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
